// ----- rtl/core/assert_macros.svh -----
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst, prop)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- rtl/core/rcfd_pkg.sv -----
`default_nettype none

package rcfd_pkg;

  localparam int FRAME_BYTES = 18;
  localparam int IDX_W       = $clog2(FRAME_BYTES);
  localparam int CH_W        = 11;
  localparam int SW_W        = 2;
  localparam int STATUS_W    = 2;
  localparam int LIMIT_W     = 10;
  localparam int WD_W        = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int NUM_CH      = 5;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd2;

  localparam logic             ENABLE_RESET  = 1'b1;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd660;
  localparam logic [WD_W-1:0]  TIMEOUT_RESET = 16'd100;

  // raw minus 1024 in 11 bits is the raw code with its top bit inverted
  function automatic logic signed [CH_W-1:0] centre(input logic [CH_W-1:0] raw);
    centre = {~raw[CH_W-1], raw[CH_W-2:0]};
  endfunction

  function automatic logic [CH_W-1:0] magnitude(input logic signed [CH_W-1:0] v);
    logic [CH_W-1:0] neg;
    neg = CH_W'(-v);
    magnitude = v[CH_W-1] ? neg : v;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/rcfd_item_if.sv -----
`default_nettype none

interface rcfd_item_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] rx_byte;

  modport source(output valid, operation, rx_byte, input ready);
  modport sink(input valid, operation, rx_byte, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/rcfd_result_if.sv -----
`default_nettype none

interface rcfd_result_if;
  logic                                valid;
  logic                                ready;
  logic signed [rcfd_pkg::CH_W-1:0]    right_x;
  logic signed [rcfd_pkg::CH_W-1:0]    right_y;
  logic signed [rcfd_pkg::CH_W-1:0]    left_x;
  logic signed [rcfd_pkg::CH_W-1:0]    left_y;
  logic signed [rcfd_pkg::CH_W-1:0]    dial_value;
  logic [rcfd_pkg::SW_W-1:0]           left_switch;
  logic [rcfd_pkg::SW_W-1:0]           right_switch;
  logic [rcfd_pkg::STATUS_W-1:0]       link_status;
  logic                                data_valid;
  logic                                frame_done;

  modport source(output valid, right_x, right_y, left_x, left_y, dial_value,
                 left_switch, right_switch, link_status, data_valid, frame_done,
                 input ready);
  modport sink(input valid, right_x, right_y, left_x, left_y, dial_value,
               left_switch, right_switch, link_status, data_valid, frame_done,
               output ready);
endinterface

`default_nettype wire

// ----- rtl/core/rcfd_cfg_if.sv -----
`default_nettype none

interface rcfd_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [rcfd_pkg::CFG_IDX_W-1:0]     reg_index;
  logic [rcfd_pkg::CFG_DATA_W-1:0]    wr_data;

  modport source(output valid, reg_index, wr_data, input ready);
  modport sink(input valid, reg_index, wr_data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/rc_receiver_frame_decoder_unit.sv -----
// Remote control receiver frame decoder.
// item channel: each transaction is a received byte (operation 0) or one
// watchdog tick (operation 1). Bytes collect into an 18-byte frame; the last
// byte of a frame triggers unpacking of five centred 11-bit channels and two
// switch codes, checked against channel_limit.
// result channel: exactly one transaction per item, carrying the held data,
// link status, data_valid and frame_done.
// cfg channel: always ready; index 0 receive_enable, 1 channel_limit,
// 2 timeout_ticks. Other indexes are ignored.
// Timing: the result is registered and presented on the cycle after the item is accepted.
// Throughput: one item per cycle when not stalled; decode is a single pass
// of unpack and compare logic between the item port and the result register.
// Reset (rst, synchronous): status running, enabled, data zero, frame and
// watchdog counters cleared, limit 660, timeout 100 ticks.
// Stall: while a result waits and result.ready is low, item.ready is low;
// the result register holds its transaction until taken.

`default_nettype none

`include "assert_macros.svh"

module rc_receiver_frame_decoder_unit (
  input  wire logic          clk,
  input  wire logic          rst,
  rcfd_item_if.sink          item,
  rcfd_result_if.source      result,
  rcfd_cfg_if.sink           cfg
);

  typedef enum logic [rcfd_pkg::STATUS_W-1:0] {
    ST_RUNNING = 2'd0,
    ST_TIMEOUT = 2'd1,
    ST_ERROR   = 2'd2,
    ST_STOPPED = 2'd3
  } link_state_t;

  localparam int LAST = rcfd_pkg::FRAME_BYTES - 1;

  logic [7:0] frame_store [rcfd_pkg::FRAME_BYTES];
  logic [7:0] frame_view  [rcfd_pkg::FRAME_BYTES];

  logic [rcfd_pkg::IDX_W-1:0]   byte_index, byte_index_next;
  logic [rcfd_pkg::WD_W-1:0]    watchdog_count, watchdog_count_next;
  logic [rcfd_pkg::WD_W-1:0]    watchdog_inc;
  link_state_t                  link_state, link_state_next;
  logic signed [rcfd_pkg::CH_W-1:0] channel_values [rcfd_pkg::NUM_CH];
  logic signed [rcfd_pkg::CH_W-1:0] channel_values_next [rcfd_pkg::NUM_CH];
  logic [rcfd_pkg::SW_W-1:0]    switch_values [2];
  logic [rcfd_pkg::SW_W-1:0]    switch_values_next [2];
  logic                         frame_done_next;

  logic                         receive_enable;
  logic [rcfd_pkg::LIMIT_W-1:0] channel_limit;
  logic [rcfd_pkg::WD_W-1:0]    timeout_ticks;

  logic                         res_valid;

  logic [rcfd_pkg::CH_W-1:0]        raw [rcfd_pkg::NUM_CH];
  logic signed [rcfd_pkg::CH_W-1:0] centred [rcfd_pkg::NUM_CH];
  logic                             bad_frame;

  logic accept_item;
  logic accept_cfg;
  logic store_byte;

  assign item.ready  = !res_valid || result.ready;
  assign cfg.ready   = 1'b1;
  assign accept_item = item.valid && item.ready;
  assign accept_cfg  = cfg.valid && cfg.ready;
  assign store_byte  = accept_item && receive_enable && (item.operation == rcfd_pkg::OP_BYTE);

  // last byte of the frame comes straight from the item port
  always_comb begin
    for (int k = 0; k < rcfd_pkg::FRAME_BYTES; k++) begin
      frame_view[k] = (k == LAST) ? item.rx_byte : frame_store[k];
    end
  end

  always_comb begin
    raw[0] = {frame_view[1][2:0], frame_view[0]};
    raw[1] = {frame_view[2][5:0], frame_view[1][7:3]};
    raw[2] = {frame_view[4][0], frame_view[3], frame_view[2][7:6]};
    raw[3] = {frame_view[5][3:0], frame_view[4][7:1]};
    raw[4] = {frame_view[17][2:0], frame_view[16]};
    bad_frame = 1'b0;
    for (int i = 0; i < rcfd_pkg::NUM_CH; i++) begin
      centred[i] = rcfd_pkg::centre(raw[i]);
      if (rcfd_pkg::magnitude(centred[i]) > {1'b0, channel_limit}) begin
        bad_frame = 1'b1;
      end
    end
  end

  assign watchdog_inc = watchdog_count + rcfd_pkg::WD_W'(1);

  always_comb begin
    byte_index_next     = byte_index;
    watchdog_count_next = watchdog_count;
    link_state_next     = link_state;
    channel_values_next = channel_values;
    switch_values_next  = switch_values;
    frame_done_next     = 1'b0;
    if (accept_item && receive_enable) begin
      if (item.operation == rcfd_pkg::OP_BYTE) begin
        if (byte_index == rcfd_pkg::IDX_W'(LAST)) begin
          byte_index_next     = '0;
          watchdog_count_next = '0;
          if (!bad_frame) begin
            channel_values_next = centred;
            switch_values_next[0] = frame_view[5][7:6];
            switch_values_next[1] = frame_view[5][5:4];
            link_state_next     = ST_RUNNING;
            frame_done_next     = 1'b1;
          end else begin
            for (int i = 0; i < rcfd_pkg::NUM_CH; i++) channel_values_next[i] = '0;
            switch_values_next[0] = '0;
            switch_values_next[1] = '0;
            link_state_next       = ST_ERROR;
          end
        end else begin
          byte_index_next = byte_index + rcfd_pkg::IDX_W'(1);
        end
      end else begin
        if (watchdog_inc >= timeout_ticks) begin
          watchdog_count_next = '0;
          byte_index_next     = '0;
          for (int i = 0; i < rcfd_pkg::NUM_CH; i++) channel_values_next[i] = '0;
          switch_values_next[0] = '0;
          switch_values_next[1] = '0;
          link_state_next       = ST_TIMEOUT;
        end else begin
          watchdog_count_next = watchdog_inc;
        end
      end
    end
    // the user must make enable changes only while idle; not enforced here
    if (accept_cfg && (cfg.reg_index == rcfd_pkg::REG_ENABLE) &&
        (cfg.wr_data[0] != receive_enable)) begin
      if (cfg.wr_data[0]) begin
        link_state_next     = ST_RUNNING;
        byte_index_next     = '0;
        watchdog_count_next = '0;
      end else begin
        link_state_next = ST_STOPPED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (store_byte) begin
      frame_store[byte_index] <= item.rx_byte;
    end
    if (accept_item) begin
      result.right_x      <= channel_values_next[0];
      result.right_y      <= channel_values_next[1];
      result.left_x       <= channel_values_next[2];
      result.left_y       <= channel_values_next[3];
      result.dial_value   <= channel_values_next[4];
      result.left_switch  <= switch_values_next[0];
      result.right_switch <= switch_values_next[1];
      result.link_status  <= link_state_next;
      result.data_valid   <= (link_state_next == ST_RUNNING);
      result.frame_done   <= frame_done_next;
    end
    if (rst) begin
      byte_index     <= '0;
      watchdog_count <= '0;
      link_state     <= ST_RUNNING;
      for (int i = 0; i < rcfd_pkg::NUM_CH; i++) channel_values[i] <= '0;
      switch_values[0] <= '0;
      switch_values[1] <= '0;
      receive_enable <= rcfd_pkg::ENABLE_RESET;
      channel_limit  <= rcfd_pkg::LIMIT_RESET;
      timeout_ticks  <= rcfd_pkg::TIMEOUT_RESET;
      res_valid      <= 1'b0;
    end else begin
      byte_index     <= byte_index_next;
      watchdog_count <= watchdog_count_next;
      link_state     <= link_state_next;
      channel_values <= channel_values_next;
      switch_values  <= switch_values_next;
      if (accept_item) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
      if (accept_cfg) begin
        unique case (cfg.reg_index)
          rcfd_pkg::REG_ENABLE:  receive_enable <= cfg.wr_data[0];
          rcfd_pkg::REG_LIMIT:   channel_limit  <= cfg.wr_data[rcfd_pkg::LIMIT_W-1:0];
          rcfd_pkg::REG_TIMEOUT: timeout_ticks  <= cfg.wr_data;
          default: ;
        endcase
      end
    end
  end

  assign result.valid = res_valid;

  `ASSERT_ALWAYS(a_index_in_frame, clk, rst, byte_index <= rcfd_pkg::IDX_W'(LAST))
  `ASSERT_ALWAYS(a_stopped_iff_disabled, clk, rst,
                 (link_state == ST_STOPPED) == !receive_enable)
  `ASSERT_ALWAYS(a_valid_matches_status, clk, rst,
                 !res_valid || (result.data_valid == (result.link_status == ST_RUNNING)))
  `ASSERT_ALWAYS(a_done_only_running, clk, rst,
                 !res_valid || !result.frame_done || (result.link_status == ST_RUNNING))
  `ASSERT_NEXT(a_item_gives_result, clk, rst, accept_item, res_valid)

endmodule

`default_nettype wire
